// File: rtl/assert_macros.svh
// Assertion macros used by the checker module lfu_chk.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/lfu_pkg.sv
// Types and constants for the LFU cache table.
// No dependencies; imported by the cell, the top level, both checkers and the bench.
package lfu_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int USE_W      = 32;
    // Slot index and recency rank fields on the chain, sized for 256 slots
    localparam int SLOT_IDX_W = 8;
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

    typedef struct packed {
        logic                     action;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [DATA_W-1:0] store_data;
    } lfu_cmd_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_data;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } lfu_result_t;

    // Token passed cell to cell: running match, first free slot, best victim
    typedef struct packed {
        logic                    hit;
        logic [SLOT_IDX_W-1:0]   hit_idx;
        logic [DATA_W-1:0]       hit_data;
        logic [SLOT_IDX_W-1:0]   hit_rank;
        logic                    free_found;
        logic [SLOT_IDX_W-1:0]   free_idx;
        logic                    vic_found;
        logic [SLOT_IDX_W-1:0]   vic_idx;
        logic [KEY_W-1:0]        vic_key;
        logic [USE_W-1:0]        vic_count;
        logic [SLOT_IDX_W-1:0]   vic_rank;
    } lfu_scan_t;

    // Update broadcast to every cell at the end of a transaction
    typedef struct packed {
        logic                  en;
        logic                  touch;
        logic                  put;
        logic [SLOT_IDX_W-1:0] tgt_idx;
        logic [SLOT_IDX_W-1:0] ref_rank;
        logic                  evict;
        logic [SLOT_IDX_W-1:0] vic_idx;
        logic [SLOT_IDX_W-1:0] vic_rank;
        logic                  insert;
        logic [SLOT_IDX_W-1:0] ins_idx;
        logic [KEY_W-1:0]      key;
        logic [DATA_W-1:0]     data;
    } lfu_upd_t;

endpackage

// File: rtl/lfu_cell.sv
// One cache slot: key, data, use count, recency rank, plus a chain stage
// that merges this slot into the scan token. Depends on lfu_pkg.
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int INDEX    = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KEY_W-1:0]  key,
    input  lfu_scan_t         scan_in,
    output lfu_scan_t         scan_out,
    input  lfu_upd_t          upd
);

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(INDEX);

    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [USE_W-1:0]  count_reg, count_next;
    logic [RW-1:0]     rank_reg, rank_next;
    lfu_scan_t         scan_reg, scan_next;

    logic [SLOT_IDX_W-1:0] my_rank;
    logic                  key_match;
    logic                  better;

    assign my_rank   = SLOT_IDX_W'(rank_reg);
    assign key_match = valid_reg && (key_reg == key);
    assign better    = valid_reg && (!scan_in.vic_found
                                     || (count_reg < scan_in.vic_count)
                                     || ((count_reg == scan_in.vic_count)
                                         && (my_rank > scan_in.vic_rank)));

    // chain stage
    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.hit && key_match)
        begin
            scan_next.hit      = 1'b1;
            scan_next.hit_idx  = MY_IDX;
            scan_next.hit_data = data_reg;
            scan_next.hit_rank = my_rank;
        end
        if (!scan_in.free_found && !valid_reg)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_idx   = MY_IDX;
        end
        if (better)
        begin
            scan_next.vic_found = 1'b1;
            scan_next.vic_idx   = MY_IDX;
            scan_next.vic_key   = key_reg;
            scan_next.vic_count = count_reg;
            scan_next.vic_rank  = my_rank;
        end
    end

    // slot update
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (upd.en)
        begin
            if (upd.touch)
            begin
                if (MY_IDX == upd.tgt_idx)
                begin
                    rank_next = '0;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + USE_W'(1);
                    end
                    if (upd.put)
                    begin
                        data_next = upd.data;
                    end
                end
                else if (valid_reg && (my_rank < upd.ref_rank))
                begin
                    rank_next = rank_reg + RW'(1);
                end
            end
            else if (upd.insert)
            begin
                if (MY_IDX == upd.ins_idx)
                begin
                    valid_next = 1'b1;
                    key_next   = upd.key;
                    data_next  = upd.data;
                    count_next = USE_W'(1);
                    rank_next  = '0;
                end
                else if (upd.evict && (MY_IDX == upd.vic_idx))
                begin
                    valid_next = 1'b0;
                end
                else if (valid_reg && !(upd.evict && (my_rank > upd.vic_rank)))
                begin
                    // not older than the victim (or no evict): +1 for insert; older: -1 +1
                    rank_next = rank_reg + RW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        data_reg  <= data_next;
        count_reg <= count_next;
        rank_reg  <= rank_next;
        scan_reg  <= scan_next;
    end

    assign scan_out = scan_reg;

endmodule

// File: rtl/lfu_cache_table.sv
// Top level of the LFU cache table: command handshake, scan sequencer,
// update decision and the row of lfu_cell slots. Depends on lfu_pkg, lfu_cell.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------
//  command  | start / busy (in at !busy)| cmd    (lfu_cmd_t)
//  result   | done strobe, one cycle    | result (lfu_result_t)
//  config   | cfg_valid / cfg_ready     | cfg_data (capacity_in_use)
//
// A transaction is a scan and an update: the scan token walks the row of
// CAPACITY cells one cell per cycle, then ST_UPDATE applies the update.
// The result strobe comes in the cycle after the update; busy is already low
// then, so the next transaction may be accepted in that same cycle.
// Reset (rst_n, async, active low) clears all slot valid bits and the fill
// count at once and sets capacity_in_use to 16; no clearing pass is needed.
// The receiver cannot stall: done is high for exactly one cycle per transaction.
module lfu_cache_table
    import lfu_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lfu_cmd_t          cmd,
    output logic              done,
    output lfu_result_t       result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (FW > CAP_W) ? FW : CAP_W;

    lfu_state_t        state_reg, state_next;
    logic [IW-1:0]     scan_cnt_reg, scan_cnt_next;
    lfu_cmd_t          cmd_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic [FW-1:0]     filled_reg, filled_next;
    logic              done_reg;
    lfu_result_t       result_reg, result_next;

    logic              accept;
    logic              upd_en;
    logic              scan_last;

    lfu_scan_t         chain [CAPACITY+1];
    lfu_scan_t         tail;
    lfu_upd_t          upd;

    // capacity limit and hit / evict decision from the finished scan
    logic [CW-1:0]     cap_ext, lim, filled_ext;
    logic              active, hit_now, miss_put, evict_now, insert_now;
    logic              take_vic;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign scan_last = (scan_cnt_reg == IW'(CAPACITY - 1));

    //----------------------------------------------------------------------
    // Sequencer
    //----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = 1'b1;
        upd_en        = 1'b0;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                busy          = 1'b0;
                scan_cnt_next = '0;
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IW'(1);
            end
            ST_UPDATE:
            begin
                upd_en = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    //----------------------------------------------------------------------
    // Row of cells; cell 0 starts from an empty token
    //----------------------------------------------------------------------
    assign chain[0] = '0;
    assign tail     = chain[CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lfu_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .key      (cmd_reg.lookup_key),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .upd      (upd)
        );
    end

    //----------------------------------------------------------------------
    // Update decision, taken in ST_UPDATE once the token reached the tail
    //----------------------------------------------------------------------
    assign cap_ext    = CW'(capacity_reg);
    assign lim        = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
    assign filled_ext = CW'(filled_reg);
    assign active     = (lim != '0);
    assign hit_now    = active && tail.hit;
    assign miss_put   = active && !tail.hit && cmd_reg.action;
    // full (or over the limit after the limit was lowered): replace a victim
    assign evict_now  = miss_put && (filled_ext >= lim) && tail.vic_found;
    assign insert_now = miss_put && (evict_now || tail.free_found);
    // lowest free slot once the victim is gone
    assign take_vic   = evict_now && (!tail.free_found || (tail.vic_idx < tail.free_idx));

    always_comb
    begin
        upd.en       = upd_en;
        upd.touch    = hit_now;
        upd.put      = cmd_reg.action;
        upd.tgt_idx  = tail.hit_idx;
        upd.ref_rank = tail.hit_rank;
        upd.evict    = evict_now;
        upd.vic_idx  = tail.vic_idx;
        upd.vic_rank = tail.vic_rank;
        upd.insert   = insert_now;
        upd.ins_idx  = take_vic ? tail.vic_idx : tail.free_idx;
        upd.key      = cmd_reg.lookup_key;
        upd.data     = cmd_reg.store_data;
    end

    always_comb
    begin
        filled_next = filled_reg;
        if (upd_en)
        begin
            filled_next = filled_reg - FW'(evict_now) + FW'(insert_now);
        end
    end

    always_comb
    begin
        result_next.hit         = hit_now;
        result_next.read_data   = (hit_now && !cmd_reg.action) ? tail.hit_data : '0;
        result_next.evicted     = evict_now;
        result_next.evicted_key = evict_now ? tail.vic_key : '0;
    end

    //----------------------------------------------------------------------
    // Registers
    //----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            capacity_reg <= CAP_RESET;
            filled_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            filled_reg   <= filled_next;
            done_reg     <= upd_en;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (upd_en)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/lfu_chk.sv
// Port-level checker for the LFU cache table, bound to the top level.
// Depends on lfu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfu_chk
    import lfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  lfu_cmd_t          cmd,
    input  logic              done,
    input  lfu_result_t       result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CAP_W-1:0]  cfg_data
);

    logic unused_ok;
    assign unused_ok = start ^ cmd.action ^ cfg_valid ^ cfg_ready ^ cfg_data[0];

    // a transaction finishes only with its result strobe
    `CHK_IMPLIES(a_busy_ends_with_done, clk, rst_n, $fell(busy), done)
    // one strobe per transaction, never two in a row
    `CHK_NEXT(a_done_single, clk, rst_n, done, !done)
    // an eviction only happens on a put that missed
    `CHK_IMPLIES(a_evict_is_miss, clk, rst_n, done && result.evicted, !result.hit)
    // nonzero read data only on a hit
    `CHK_IMPLIES(a_data_needs_hit, clk, rst_n,
        done && (result.read_data != 0), result.hit)

endmodule

bind lfu_cache_table lfu_chk u_lfu_chk (.*);

// File: verif/lfu_result_checker.sv
// Checker for the LFU cache table: predicts each get/put outcome and compares it.
// Holds the action codes package used by the bench; depends on lfu_pkg.
`timescale 1ns / 100ps

package lfu_action_pkg;
    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } lfu_action_e;
endpackage

module lfu_result_checker
    import lfu_pkg::*;
    import lfu_action_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  lfu_cmd_t         cmd,
    input  logic             done,
    input  lfu_result_t      result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CAP_W-1:0] cfg_data,
    output int               mismatch_count,
    output int               outstanding,
    output int               hit_count,
    output int               eviction_count
);

    localparam int RANK_W     = $clog2(SLOTS);
    localparam int REPORT_MAX = 10;

    // Shadow copy of the table
    logic              slot_live  [SLOTS];
    logic [KEY_W-1:0]  slot_tag   [SLOTS];
    logic [DATA_W-1:0] slot_value [SLOTS];
    logic [USE_W-1:0]  slot_uses  [SLOTS];
    logic [RANK_W-1:0] slot_rank  [SLOTS];
    logic [CAP_W-1:0]  fill_level;
    logic [CAP_W-1:0]  capacity_setting;

    lfu_result_t predicted_outcomes [$];
    lfu_result_t oldest;
    int          fail_tally;
    int          hit_tally;
    int          evict_tally;

    // Most recent goes to rank 0, everything that was more recent slides back one
    function automatic void promote(input int s);
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i] && i != s && slot_rank[i] < slot_rank[s])
                slot_rank[i] = slot_rank[i] + 1'b1;
        slot_rank[s] = '0;
        if (slot_uses[s] != '1)
            slot_uses[s] = slot_uses[s] + 1'b1;
    endfunction

    function automatic lfu_result_t cache_access(input lfu_cmd_t c);
        lfu_result_t       r;
        int                limit;
        int                found;
        int                victim;
        int                free_slot;
        logic [RANK_W-1:0] gone_rank;
        r         = '0;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        limit     = (capacity_setting < SLOTS) ? int'(capacity_setting) : SLOTS;
        if (limit == 0)
            return r;
        for (int i = 0; i < SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_tag[i] == c.lookup_key)
                found = i;
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (c.action == ACT_GET)
                r.read_data = slot_value[found];
            else
                slot_value[found] = c.store_data;
            promote(found);
            return r;
        end
        if (c.action == ACT_GET)
            return r;
        // Insert path; full (or over the limit after a shrink) means one victim goes first
        if (fill_level >= limit)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                    (slot_uses[i] == slot_uses[victim] && slot_rank[i] > slot_rank[victim])))
                    victim = i;
            if (victim >= 0)
            begin
                r.evicted       = 1'b1;
                r.evicted_key   = slot_tag[victim];
                gone_rank       = slot_rank[victim];
                slot_live[victim] = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && slot_rank[i] > gone_rank)
                        slot_rank[i] = slot_rank[i] - 1'b1;
                if (fill_level > 0)
                    fill_level = fill_level - 1'b1;
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (free_slot < 0 && !slot_live[i])
                free_slot = i;
        if (free_slot >= 0)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot_live[i])
                    slot_rank[i] = slot_rank[i] + 1'b1;
            slot_live[free_slot]  = 1'b1;
            slot_tag[free_slot]   = c.lookup_key;
            slot_value[free_slot] = c.store_data;
            slot_uses[free_slot]  = 1;
            slot_rank[free_slot]  = '0;
            fill_level = fill_level + 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_tag[i]   = '0;
                slot_value[i] = '0;
                slot_uses[i]  = '0;
                slot_rank[i]  = '0;
            end
            fill_level       = '0;
            capacity_setting = CAP_RESET;
            predicted_outcomes.delete();
            fail_tally     = 0;
            hit_tally      = 0;
            evict_tally    = 0;
            mismatch_count <= 0;
            outstanding    <= 0;
            hit_count      <= 0;
            eviction_count <= 0;
        end
        else
        begin
            // Retire the result first; a new command may be taken on the same edge
            if (done)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    fail_tally++;
                    if (fail_tally <= REPORT_MAX)
                        $display("[%0t] result strobe with no transaction pending", $time);
                end
                else
                begin
                    oldest = predicted_outcomes.pop_front();
                    if (result.hit !== oldest.hit || result.read_data !== oldest.read_data ||
                        result.evicted !== oldest.evicted ||
                        result.evicted_key !== oldest.evicted_key)
                    begin
                        fail_tally++;
                        if (fail_tally <= REPORT_MAX)
                            $display({"[%0t] result mismatch: exp hit=%0b data=%h ev=%0b key=%h",
                                      " / got hit=%0b data=%h ev=%0b key=%h"}, $time,
                                     oldest.hit, oldest.read_data, oldest.evicted,
                                     oldest.evicted_key, result.hit, result.read_data,
                                     result.evicted, result.evicted_key);
                    end
                    else
                    begin
                        if (oldest.hit)
                            hit_tally++;
                        if (oldest.evicted)
                            evict_tally++;
                    end
                end
            end
            if (start && !busy)
                predicted_outcomes.push_back(cache_access(cmd));
            if (cfg_valid && cfg_ready)
                capacity_setting = cfg_data;
            mismatch_count <= fail_tally;
            outstanding    <= predicted_outcomes.size();
            hit_count      <= hit_tally;
            eviction_count <= evict_tally;
        end
    end

endmodule

// File: verif/tb_top.sv
// Testbench top for the LFU cache table: clock, reset, get/put stimulus, verdict.
// Depends on lfu_pkg, lfu_cache_table and lfu_result_checker (with lfu_action_pkg).
`timescale 1ns / 100ps

module tb_top;
    import lfu_pkg::*;
    import lfu_action_pkg::*;

    localparam int SLOTS       = 16;
    // The slowest run (~775 transactions, each a scan and an update, plus sender
    // gaps) stays far below CYCLE_LIMIT; this leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;
    localparam int KEY_POOL    = 32;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    lfu_cmd_t         cmd       = '0;
    logic             done;
    lfu_result_t      result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int outstanding;
    int hit_count;
    int eviction_count;

    int idle_pct    = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    // Random keys reused across transactions so gets hit and puts collide
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lfu_cache_table #(
        .CAPACITY (SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lfu_result_checker #(
        .SLOTS (SLOTS)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .done           (done),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding),
        .hit_count      (hit_count),
        .eviction_count (eviction_count)
    );

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One command transaction. start is left high on return so the next call
    // can go back to back; every caller either sends again or lowers start in
    // the same time step, so a stale command never sits on the port.
    task automatic send_cmd(input logic act, input logic [KEY_W-1:0] k,
                            input logic [DATA_W-1:0] d);
        lfu_cmd_t next_cmd;
        int       gap;
        next_cmd.action     = act;
        next_cmd.lookup_key = k;
        next_cmd.store_data = d;
        gap = 0;
        if (idle_pct > 0)
        begin
            // Occasional long gap so the raise of start lands anywhere in the
            // scan/update sequence, plus per-cycle idling at the phase rate
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, SLOTS + 3);
            while ($urandom_range(0, 99) < idle_pct)
                gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= next_cmd;
        // accepted at the first edge where busy was low
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // Sender holds off until every predicted result has been retired
    task automatic wait_for_results;
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Capacity is only changed with the table idle
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random get/put mix. The key window scales with the capacity so the
    // table sees both hits and steady eviction pressure.
    task automatic run_random(input int cap, input int pct, input int count);
        int               eff;
        int               window;
        logic [KEY_W-1:0] k;
        set_capacity(cap[CAP_W-1:0]);
        eff    = (cap < SLOTS) ? cap : SLOTS;
        window = eff + eff / 2 + 2;
        if (window > KEY_POOL)
            window = KEY_POOL;
        for (int n = 0; n < count; n++)
        begin
            // stretches of 25 transactions; some of them run with no idling
            if (n % 25 == 0)
                idle_pct = ($urandom_range(0, 3) == 0) ? 0 : pct;
            if ($urandom_range(0, 9) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(0, window - 1)];
            send_cmd(1'($urandom_range(0, 1)), k, $urandom);
            // now and then let the table drain completely mid-phase
            if ($urandom_range(0, 63) == 0)
                wait_for_results();
        end
        idle_pct = 0;
    endtask

    initial
    begin
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset capacity of 16
        send_cmd(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // empty table, data ignored
        send_cmd(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);  // extreme key and value
        send_cmd(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'h8000_0000, 32'hFFFF_FFFF);  // put hit: read_data stays 0
        send_cmd(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(ACT_GET, 32'hFFFF_FFFF, 32'h1234_5678);

        // Limit equal to the fill: two entries tie on use count, the older one goes
        set_capacity(5'd3);
        send_cmd(ACT_PUT, 32'h0000_0005, 32'h0000_0055);
        send_cmd(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // Limit below the fill: stored keys still hit, each insert swaps one out
        set_capacity(5'd1);
        send_cmd(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'h0000_0006, 32'h0000_0066);
        send_cmd(ACT_PUT, 32'h0000_0007, 32'h0000_0077);
        send_cmd(ACT_GET, 32'h8000_0000, 32'h0000_0000);

        // Zero capacity: gets miss even on stored keys, puts are dropped
        set_capacity(5'd0);
        send_cmd(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'h0000_0008, 32'h0000_0088);

        // Above the slot count the limit saturates
        set_capacity(5'd31);
        send_cmd(ACT_GET, 32'h0000_0008, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'h0000_0009, 32'hAAAA_AAAA);
        send_cmd(ACT_PUT, 32'h0000_000A, 32'h5555_5555);
        send_cmd(ACT_GET, 32'h0000_0009, 32'h0000_0000);
        send_cmd(ACT_PUT, 32'h0000_0009, 32'h0000_0001);

        // Random part: capacities and sender idling vary by phase
        run_random(16, 0, 100);
        run_random(4, 59, 100);
        run_random(31, 8, 100);
        run_random(1, 0, 80);
        run_random(8, 59, 100);
        run_random(0, 8, 40);
        run_random(2, 59, 100);
        run_random(16, 8, 130);

        // Drain, then give a late or stray strobe time to show up
        wait_for_results();
        repeat (SLOTS + 4) @(posedge clk);

        $display("Ran %0d get/put transactions at capacity limits 0, 1, 2, 3, 4, 8, 16, 31,",
                 items_sent);
        $display("%0d hits and %0d evictions matched the predicted table contents.",
                 hit_count, eviction_count);
        if (mismatch_count == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
